// ===== sv/cpcd_pkg.sv =====
package cpcd_pkg;

  localparam int CHAR_W = 8;
  localparam int CODE_W = 8;
  // Codes are CODE_W bits wide, so the dictionary never holds more entries than this.
  localparam int TABLE_DEPTH = 256;

  // Lookup request as it travels down the cell chain.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] left;
    logic [CHAR_W-1:0] right;
    logic              last;
    logic              done;    // matched or stored by some cell
    logic              is_new;  // stored by this lookup
    logic [CODE_W-1:0] code;
  } query_t;

endpackage

// ===== sv/cpcd_if.sv =====
interface cpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       row_end;

  modport source (output valid, output char_code, output row_end, input ready);
  modport sink   (input valid, input char_code, input row_end, output ready);
endinterface

interface cpcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pair_code;
  logic       is_new;
  logic [7:0] left_char;
  logic [7:0] right_char;
  logic       row_last;
  logic       overflow;

  modport source (output valid, output pair_code, output is_new, output left_char,
                  output right_char, output row_last, output overflow, input ready);
  modport sink   (input valid, input pair_code, input is_new, input left_char,
                  input right_char, input row_last, input overflow, output ready);
endinterface

// ===== sv/cpcd_cell.sv =====
module cpcd_cell
  import cpcd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  query_t q_in,
  output query_t q_out
);

  localparam logic [CODE_W-1:0] CODE = CODE_W'(IDX);

  logic                  ent_valid;
  logic [2*CHAR_W-1:0]   ent_key;
  logic                  open_q;
  logic                  hit;
  logic                  take;
  query_t                q_next;

  // Only queries that no earlier cell has served look at this entry.
  assign open_q = q_in.valid && !q_in.done;
  assign hit    = open_q && ent_valid && (ent_key == {q_in.left, q_in.right});
  assign take   = open_q && !ent_valid;

  always_comb begin
    q_next = q_in;
    if (hit || take) begin
      q_next.done   = 1'b1;
      q_next.is_new = take;
      q_next.code   = CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
      ent_valid   <= (IDX == 0);   // entry 0 holds pair (0,0) from reset on
      ent_key     <= '0;
    end else if (advance) begin
      q_out <= q_next;
      if (take) begin
        ent_valid <= 1'b1;
        ent_key   <= {q_in.left, q_in.right};
      end
    end
  end

endmodule

// ===== sv/char_pair_code_dictionary.sv =====
// Channel | Dir | Words                              | Payload
// chars   | in  | one character of a row             | char_code, row_end
// codes   | out | one per character, +1 at row end   | pair_code, is_new, left_char,
//         |     |                                    | right_char, row_last, overflow
//
// Flow: a character makes one lookup at the input, two when it ends its row (the
// pair lookup, then the (last,0) lookup). Each lookup walks a chain of one cell per
// dictionary entry, one cell a cycle while the output word is not held, and its result
// is registered after the last cell; lookups stream back to back through the chain.
// Reset: synchronous; clears the chain, leaves only entry 0 = (0,0) valid.
// Stalls: a held output word freezes the whole chain and the input together.
module char_pair_code_dictionary
  import cpcd_pkg::*;
#(
  parameter int MAX_CODES = 256
) (
  input  logic             clk,
  input  logic             rst,
  cpcd_in_if.sink          chars,
  cpcd_out_if.source       codes
);

  // Number of cells: one per usable code.
  localparam int NCELLS = (MAX_CODES < TABLE_DEPTH) ? MAX_CODES : TABLE_DEPTH;

  query_t            link [NCELLS+1];
  logic              advance;
  logic              pend;        // row-end lookup still to issue
  logic [CHAR_W-1:0] pend_char;
  logic [CHAR_W-1:0] prev_char;
  logic              ovf_seen;
  logic              ovf_next;
  logic              out_valid;
  logic              miss;
  query_t            head;
  query_t            tail;

  // Move everything one step whenever the output word is free or being taken.
  assign advance     = !out_valid || codes.ready;
  assign chars.ready = advance && !pend;

  // Form the lookup that enters the chain this cycle.
  always_comb begin
    head        = '0;
    head.valid  = 1'b0;
    if (pend) begin
      head.valid = 1'b1;
      head.left  = pend_char;
      head.right = '0;
      head.last  = 1'b1;
    end else if (chars.valid) begin
      head.valid = 1'b1;
      head.left  = prev_char;
      head.right = chars.char_code;
      head.last  = 1'b0;
    end
  end

  assign link[0] = head;

  // Row of dictionary cells; entry i lives in cell i and answers with code i.
  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    cpcd_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .q_in    (link[g]),
      .q_out   (link[g+1])
    );
  end

  assign tail     = link[NCELLS];
  // A lookup that leaves the chain unserved found the dictionary full.
  assign miss     = tail.valid && !tail.done;
  assign ovf_next = ovf_seen || miss;

  // Track the previous character and the pending row-end lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      prev_char <= '0;
    end else if (advance) begin
      if (pend) begin
        pend <= 1'b0;
      end else if (chars.valid) begin
        if (chars.row_end) begin
          pend      <= 1'b1;
          pend_char <= chars.char_code;
          prev_char <= '0;
        end else begin
          prev_char <= chars.char_code;
        end
      end
    end
  end

  // Output word register; drop the code on overflow and hold the sticky flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ovf_seen  <= 1'b0;
    end else if (advance) begin
      out_valid <= tail.valid;
      if (tail.valid) begin
        ovf_seen         <= ovf_next;
        codes.pair_code  <= tail.done ? tail.code : '0;
        codes.is_new     <= tail.done && tail.is_new;
        codes.left_char  <= tail.left;
        codes.right_char <= tail.right;
        codes.row_last   <= tail.last;
        codes.overflow   <= ovf_next;
      end
    end
  end

  assign codes.valid = out_valid;

endmodule

// ===== tb/tb.sv =====
module tb;
  import cpcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Dictionary size handed to the block; the code width caps it at TABLE_DEPTH.
  localparam int DICT_CODES = 256;
  localparam int CODE_LIMIT = (DICT_CODES < TABLE_DEPTH) ? DICT_CODES : TABLE_DEPTH;
  localparam int RAND_ITEMS = 750;
  // A lookup walks one cell per entry before its word leaves the block.
  localparam int TAIL_CYCLES = TABLE_DEPTH + 64;
  localparam int HOLD_CYCLES = 800;
  localparam int HOLD_AFTER = 420;
  localparam int CYCLE_LIMIT = 200000;

  // One output word as the block should emit it.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              fresh;
    logic [CHAR_W-1:0] left_c;
    logic [CHAR_W-1:0] right_c;
    logic              last;
    logic              full;
  } code_word_t;

  // One character waiting to be sent, with the idle cycles to put in front of it.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              row_end;
    int unsigned       gap;
    bit                drain;  // hold it back until every expected word is in
  } char_item_t;

  logic clk;
  logic rst;

  cpcd_in_if  chars();
  cpcd_out_if codes();

  char_pair_code_dictionary #(
    .MAX_CODES(DICT_CODES)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .chars(chars),
    .codes(codes)
  );

  char_item_t  char_queue[$];
  code_word_t  expected_codes[$];

  // Shadow copy of the dictionary and row state.
  logic [2*CHAR_W-1:0] dict_pair [TABLE_DEPTH];
  bit                  dict_valid[TABLE_DEPTH];
  int unsigned         codes_used;
  logic [CHAR_W-1:0]   prev_char;
  bit                  dict_full_seen;

  int unsigned chars_taken;
  int unsigned words_seen;
  int unsigned bad_words;
  int unsigned cycle_count;

  // Clock, and every input of the block at a known level from time zero.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    chars.valid = 1'b0;
    chars.char_code = '0;
    chars.row_end = 1'b0;
    codes.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  // Look a pair up in the shadow dictionary; store it when unseen and there is room.
  function automatic code_word_t lookup_pair(logic [CHAR_W-1:0] l, logic [CHAR_W-1:0] r,
                                             logic last);
    code_word_t          w;
    logic [2*CHAR_W-1:0] key;
    int                  hit;
    key = {l, r};
    hit = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && dict_valid[i] && dict_pair[i] == key) hit = i;
    w.fresh = 1'b0;
    if (hit >= 0) begin
      w.code = CODE_W'(hit);
    end else if (codes_used < CODE_LIMIT) begin
      // Unseen pair: take the next sequential code.
      w.code = CODE_W'(codes_used);
      dict_pair[codes_used] = key;
      dict_valid[codes_used] = 1'b1;
      codes_used++;
      w.fresh = 1'b1;
    end else begin
      // Dictionary full: emit code 0 and latch the sticky flag.
      w.code = '0;
      dict_full_seen = 1'b1;
    end
    w.left_c = l;
    w.right_c = r;
    w.last = last;
    w.full = dict_full_seen;
    return w;
  endfunction

  // Idle cycles before an item; some windows run with no gaps at all.
  function automatic int unsigned pick_gap(int unsigned idx);
    if ((idx >= 100 && idx < 200) || (idx >= 560 && idx < 620)) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic void queue_char(logic [CHAR_W-1:0] ch, logic row_end, bit drain = 1'b0);
    char_item_t it;
    it.ch = ch;
    it.row_end = row_end;
    it.gap = pick_gap(char_queue.size());
    it.drain = drain;
    char_queue = {char_queue, it};
  endfunction

  // Driver: present the head of char_queue after its gap; predict each accepted word.
  int unsigned idle_left;
  always @(posedge clk) begin
    char_item_t it;
    bit         fire;
    if (rst) begin
      chars.valid <= 1'b0;
      chars.char_code <= '0;
      chars.row_end <= 1'b0;
      idle_left = 0;
      chars_taken = 0;
      // Dictionary after reset: only entry 0, the pair (0,0), is valid.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        dict_pair[i] = '0;
        dict_valid[i] = 1'b0;
      end
      dict_valid[0] = 1'b1;
      codes_used = 1;
      prev_char = '0;
      dict_full_seen = 1'b0;
    end else begin
      fire = chars.valid && chars.ready;
      if (fire) begin
        chars_taken++;
        // Pair with the previous character first, then the row-end pair (char,0).
        expected_codes = {expected_codes, lookup_pair(prev_char, chars.char_code, 1'b0)};
        if (chars.row_end) begin
          expected_codes = {expected_codes, lookup_pair(chars.char_code, '0, 1'b1)};
          prev_char = '0;
        end else begin
          prev_char = chars.char_code;
        end
        idle_left = (char_queue.size() > 0) ? char_queue[0].gap : 0;
      end
      // Only touch the channel when no word is held waiting for ready.
      if (!chars.valid || fire) begin
        if (idle_left > 0) begin
          idle_left--;
          chars.valid <= 1'b0;
        end else if (char_queue.size() > 0 &&
                     !(char_queue[0].drain && expected_codes.size() > 0)) begin
          it = char_queue.pop_front();
          chars.valid <= 1'b1;
          chars.char_code <= it.ch;
          chars.row_end <= it.row_end;
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold of the receiver: once enough characters are in, count it down
  // so the chain freezes and the input backs up.
  int unsigned hold_left;
  bit          hold_done;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted word against the oldest expectation, then
  // draw the stall before the next one.
  int unsigned stall_left;
  always @(posedge clk) begin
    code_word_t want;
    code_word_t got;
    if (rst) begin
      codes.ready <= 1'b0;
      stall_left = 0;
      words_seen = 0;
      bad_words = 0;
    end else begin
      if (codes.valid && codes.ready) begin
        got.code = codes.pair_code;
        got.fresh = codes.is_new;
        got.left_c = codes.left_char;
        got.right_c = codes.right_char;
        got.last = codes.row_last;
        got.full = codes.overflow;
        if (expected_codes.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: word with nothing expected: code=%0d new=%0b pair=(%0d,%0d) %s",
                     $realtime, got.code, got.fresh, got.left_c, got.right_c,
                     $sformatf("last=%0b ovf=%0b", got.last, got.full));
        end else begin
          want = expected_codes.pop_front();
          if (got.code !== want.code || got.fresh !== want.fresh ||
              got.left_c !== want.left_c || got.right_c !== want.right_c ||
              got.last !== want.last || got.full !== want.full) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("%0t: word %0d mismatch", $realtime, words_seen);
              $display("  expected code=%0d new=%0b pair=(%0d,%0d) last=%0b ovf=%0b",
                       want.code, want.fresh, want.left_c, want.right_c, want.last, want.full);
              $display("  actual   code=%0d new=%0b pair=(%0d,%0d) last=%0b ovf=%0b",
                       got.code, got.fresh, got.left_c, got.right_c, got.last, got.full);
            end
          end
        end
        words_seen++;
        // Every third window of 250 words takes words with no stall.
        stall_left = ((words_seen / 250) % 3 == 2) ? 0 : $urandom_range(0, 15);
      end
      if (hold_left > 0) begin
        codes.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        codes.ready <= 1'b0;
      end else begin
        codes.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus: directed rows, then random rows; wait for the last word and report.
  initial begin
    logic [CHAR_W-1:0] alpha[6];
    logic [CHAR_W-1:0] ch;
    int unsigned       row_len;
    int unsigned       n;
    int unsigned       k;
    int unsigned       pick;

    // Pair (0,0) at row start: found at code 0, never new.
    queue_char(8'h00, 1'b0);
    // Row end on 0: both lookups hit the preset pair.
    queue_char(8'h00, 1'b1);
    // Single-character row with the top code: (0,255) and (255,0) both new.
    queue_char(8'hFF, 1'b1);
    // Repeat of a known start, a fresh (255,255), then a row end on 0.
    queue_char(8'hFF, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b1);
    // Alternating bit patterns, then the same row again: all hits the second time.
    queue_char(8'h55, 1'b0);
    queue_char(8'hAA, 1'b0);
    queue_char(8'hAA, 1'b1);
    queue_char(8'h55, 1'b0);
    queue_char(8'hAA, 1'b0);
    queue_char(8'hAA, 1'b1);
    // Low and high single bits, and a 0 inside a row.
    queue_char(8'h01, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(8'h7F, 1'b1);

    // Small alphabet first so pairs repeat; then mostly full-range characters,
    // which fill the dictionary and drive it into overflow.
    for (int i = 0; i < 6; i++) alpha[i] = CHAR_W'($urandom_range(0, 255));
    n = 0;
    while (n < RAND_ITEMS) begin
      row_len = $urandom_range(1, 12);
      k = 0;
      while (k < row_len && n < RAND_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) ch = '0;
        else if (n < 300 || pick < 4) ch = alpha[$urandom_range(0, 5)];
        else ch = CHAR_W'($urandom_range(0, 255));
        // Pause the sender until the block drains: once before the random
        // part, once in the middle of it.
        queue_char(ch, k == row_len - 1, n == 0 || n == 600);
        k++;
        n++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, away from the driving edge.
    @(negedge clk);
    while (char_queue.size() > 0 || chars.valid || expected_codes.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
